// ----- design/mmpv_pkg.sv -----
// Shared constants and helpers for the modular matrix power vector block.
`timescale 1ns / 1ps

package mmpv_pkg;

    localparam int VAL_W  = 62;
    localparam int EXP_W  = 63;
    localparam int IDX_W  = 4;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_MATRIX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VECTOR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_SIZE    = 1'b1;

    typedef logic [VAL_W-1:0] val_t;

    function automatic val_t add_mod(input val_t a, input val_t b, input val_t m);
        logic [VAL_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[VAL_W-1:0];
    endfunction

endpackage

// ----- design/modular_matrix_power_vector.sv -----
// Top level: modular matrix power times vector engine.
//
// Input channel s_axis: tuser carries the item kind (matrix load, vector
// load, start); tdata carries row, col, entry value and exponent. Loads are
// reduced modulo the modulus by a bit-serial divider. A start first reduces
// the stored matrix again. It then raises the matrix to the exponent by
// square-and-multiply and multiplies the power by the vector. Each product
// term uses a double-and-add modular multiplier, and up to two matrix
// products are run per exponent bit. The final matrix-vector pass reduces
// each vector entry before its product term.
// Output channel m_axis carries one transaction per result entry, the last
// one flagged by tlast. The engine takes no input while a start is in work.
// A stalled receiver holds the output register and stops the matrix-vector
// pass until the entry is taken; loads are still accepted while the last
// result waits. Reset clears the matrix and vector stores (valid bits),
// sets the modulus to 1000000007 and the size to 16. Configuration is
// written through wr_en/wr_index/wr_data; the user must do so only while
// the engine is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module modular_matrix_power_vector
    import mmpv_pkg::*;
#(
    parameter int DIM = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // row[3:0], col[7:4], entry_value[69:8], exponent[132:70], zero pad
    input  logic [135:0]       s_axis_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]  s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // index[3:0], result_value[65:4], zero pad
    output logic [71:0]        m_axis_tdata,
    output logic               m_axis_tlast,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [VAL_W-1:0]   wr_data
);

    localparam int LIM = (DIM < 16) ? DIM : 16;
    localparam int ENT = LIM * LIM;
    localparam int AW  = (ENT > 1) ? $clog2(ENT) : 1;
    localparam int RW  = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int WAW = AW + 2;

    localparam logic [1:0] RG_P = 2'd0;
    localparam logic [1:0] RG_B = 2'd1;
    localparam logic [1:0] RG_S = 2'd2;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MOD     = 5'd1;
    localparam logic [4:0] S_MUL     = 5'd2;
    localparam logic [4:0] S_LDWR    = 5'd3;
    localparam logic [4:0] S_IN_RD   = 5'd4;
    localparam logic [4:0] S_IN_MOD  = 5'd5;
    localparam logic [4:0] S_IN_WR   = 5'd6;
    localparam logic [4:0] S_IN_WR2  = 5'd7;
    localparam logic [4:0] S_LOOP    = 5'd8;
    localparam logic [4:0] S_MM_RX   = 5'd9;
    localparam logic [4:0] S_MM_RY   = 5'd10;
    localparam logic [4:0] S_MM_GO   = 5'd11;
    localparam logic [4:0] S_MM_ACC  = 5'd12;
    localparam logic [4:0] S_MM_WR   = 5'd13;
    localparam logic [4:0] S_CP_RD   = 5'd14;
    localparam logic [4:0] S_CP_WR   = 5'd15;
    localparam logic [4:0] S_MV_RD   = 5'd16;
    localparam logic [4:0] S_MV_MOD  = 5'd17;
    localparam logic [4:0] S_MV_GO   = 5'd18;
    localparam logic [4:0] S_MV_ACC  = 5'd19;
    localparam logic [4:0] S_MV_OUT  = 5'd20;

    localparam logic [5:0] LAST_BIT = 6'(VAL_W - 1);

    function automatic logic [AW-1:0] ent(input logic [4:0] r, input logic [4:0] c);
        logic [9:0] t;
        t = 10'(r) * 10'(LIM) + 10'(c);
        return t[AW-1:0];
    endfunction

    logic [4:0]       state_reg, state_next, ret_reg, ret_next;
    val_t             mod_reg, mod_next;
    logic [4:0]       size_reg, size_next;
    logic [EXP_W-1:0] e_reg, e_next;
    logic             op_reg, op_next;
    logic [4:0]       s_reg, s_next, ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next;
    logic [1:0]       xr_reg, xr_next, yr_reg, yr_next, dr_reg, dr_next;
    val_t             md_a_reg, md_a_next, md_rem_reg, md_rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    val_t             mu_a_reg, mu_a_next, mu_b_reg, mu_b_next, mu_acc_reg, mu_acc_next;
    val_t             sum_reg, sum_next;
    logic [AW-1:0]    ld_addr_reg, ld_addr_next;
    logic [RW-1:0]    ld_vaddr_reg, ld_vaddr_next;
    logic             ld_vec_reg, ld_vec_next;
    logic             ov_reg, ov_next, olast_reg, olast_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;
    val_t             oval_reg, oval_next;

    val_t             mem_m [ENT];
    logic [ENT-1:0]   mvld_reg;
    val_t             mrd_reg;
    logic             mrdv_reg;
    val_t             mem_v [LIM];
    logic [LIM-1:0]   vvld_reg;
    val_t             vrd_reg;
    logic             vrdv_reg;
    val_t             mem_w [4*ENT];
    val_t             wrd_reg;

    logic             m_we, v_we, w_we;
    logic [AW-1:0]    m_raddr;
    logic [RW-1:0]    v_raddr;
    logic [WAW-1:0]   w_raddr, w_waddr;
    val_t             w_wdata;

    val_t             meff;
    logic [4:0]       size_eff;
    logic [VAL_W:0]   rs;
    val_t             rem_step;
    logic             in_acc;
    logic [1:0]       kind;
    logic [3:0]       in_row, in_col;
    val_t             in_val;
    logic             last_j, last_i, last_k;

    assign meff = (mod_reg == '0) ? val_t'(1) : mod_reg;
    assign size_eff = (size_reg == 5'd0) ? 5'd1 :
                      ((size_reg > 5'(LIM)) ? 5'(LIM) : size_reg);
    assign rs = {md_rem_reg, md_a_reg[VAL_W-1]};
    assign rem_step = (rs >= {1'b0, meff}) ? VAL_W'(rs - {1'b0, meff}) : rs[VAL_W-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign kind   = s_axis_tuser;
    assign in_row = s_axis_tdata[3:0];
    assign in_col = s_axis_tdata[7:4];
    assign in_val = s_axis_tdata[69:8];

    assign last_j = (cj_reg + 5'd1 == s_reg);
    assign last_i = (ci_reg + 5'd1 == s_reg);
    assign last_k = (ck_reg + 5'd1 == s_reg);

    assign m_raddr = ent(ci_reg, cj_reg);
    assign v_raddr = cj_reg[RW-1:0];

    always_comb
    begin
        case (state_reg)
            S_MM_RX: w_raddr = {xr_reg, ent(ci_reg, ck_reg)};
            S_MM_RY: w_raddr = {yr_reg, ent(ck_reg, cj_reg)};
            S_CP_RD: w_raddr = {RG_S, ent(ci_reg, cj_reg)};
            default: w_raddr = {RG_P, ent(ci_reg, cj_reg)};
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        mod_next      = mod_reg;
        size_next     = size_reg;
        e_next        = e_reg;
        op_next       = op_reg;
        s_next        = s_reg;
        ci_next       = ci_reg;
        cj_next       = cj_reg;
        ck_next       = ck_reg;
        xr_next       = xr_reg;
        yr_next       = yr_reg;
        dr_next       = dr_reg;
        md_a_next     = md_a_reg;
        md_rem_next   = md_rem_reg;
        cnt_next      = cnt_reg;
        mu_a_next     = mu_a_reg;
        mu_b_next     = mu_b_reg;
        mu_acc_next   = mu_acc_reg;
        sum_next      = sum_reg;
        ld_addr_next  = ld_addr_reg;
        ld_vaddr_next = ld_vaddr_reg;
        ld_vec_next   = ld_vec_reg;
        ov_next       = ov_reg && !m_axis_tready;
        olast_next    = olast_reg;
        oidx_next     = oidx_reg;
        oval_next     = oval_reg;
        m_we          = 1'b0;
        v_we          = 1'b0;
        w_we          = 1'b0;
        w_waddr       = {RG_P, ent(ci_reg, cj_reg)};
        w_wdata       = '0;

        if (wr_en)
        begin
            case (wr_index)
                REG_MODULUS: mod_next = wr_data;
                REG_SIZE:    size_next = wr_data[4:0];
                default:     mod_next = mod_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    md_a_next     = in_val;
                    md_rem_next   = '0;
                    cnt_next      = '0;
                    ret_next      = S_LDWR;
                    ld_addr_next  = ent({1'b0, in_row}, {1'b0, in_col});
                    ld_vaddr_next = in_row[RW-1:0];
                    case (kind)
                        KIND_MATRIX:
                        begin
                            ld_vec_next = 1'b0;
                            if ({1'b0, in_row} < 5'(LIM) && {1'b0, in_col} < 5'(LIM))
                            begin
                                state_next = S_MOD;
                            end
                        end
                        KIND_VECTOR:
                        begin
                            ld_vec_next = 1'b1;
                            if ({1'b0, in_row} < 5'(LIM))
                            begin
                                state_next = S_MOD;
                            end
                        end
                        KIND_START:
                        begin
                            e_next     = s_axis_tdata[132:70];
                            op_next    = 1'b0;
                            s_next     = size_eff;
                            ci_next    = '0;
                            cj_next    = '0;
                            state_next = S_IN_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                md_a_next   = {md_a_reg[VAL_W-2:0], 1'b0};
                md_rem_next = rem_step;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = ret_reg;
                end
            end
            S_MUL:
            begin
                if (mu_b_reg[0])
                begin
                    mu_acc_next = add_mod(mu_acc_reg, mu_a_reg, meff);
                end
                mu_a_next = add_mod(mu_a_reg, mu_a_reg, meff);
                mu_b_next = mu_b_reg >> 1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = ret_reg;
                end
            end
            S_LDWR:
            begin
                m_we       = !ld_vec_reg;
                v_we       = ld_vec_reg;
                state_next = S_IDLE;
            end
            S_IN_RD:
            begin
                state_next = S_IN_MOD;
            end
            S_IN_MOD:
            begin
                md_a_next   = mrdv_reg ? mrd_reg : '0;
                md_rem_next = '0;
                cnt_next    = '0;
                ret_next    = S_IN_WR;
                state_next  = S_MOD;
            end
            S_IN_WR:
            begin
                w_we    = 1'b1;
                w_waddr = {RG_P, ent(ci_reg, cj_reg)};
                w_wdata = (ci_reg == cj_reg && meff != val_t'(1)) ? val_t'(1) : '0;
                state_next = S_IN_WR2;
            end
            S_IN_WR2:
            begin
                w_we    = 1'b1;
                w_waddr = {RG_B, ent(ci_reg, cj_reg)};
                w_wdata = md_rem_reg;
                cj_next = cj_reg + 5'd1;
                state_next = S_IN_RD;
                if (last_j)
                begin
                    cj_next = '0;
                    ci_next = ci_reg + 5'd1;
                    if (last_i)
                    begin
                        ci_next    = '0;
                        state_next = S_LOOP;
                    end
                end
            end
            S_LOOP:
            begin
                ci_next  = '0;
                cj_next  = '0;
                ck_next  = '0;
                sum_next = '0;
                if (!op_reg)
                begin
                    op_next = 1'b1;
                    if (e_reg == '0)
                    begin
                        state_next = S_MV_RD;
                    end
                    else if (e_reg[0])
                    begin
                        xr_next    = RG_P;
                        yr_next    = RG_B;
                        dr_next    = RG_P;
                        state_next = S_MM_RX;
                    end
                end
                else
                begin
                    op_next = 1'b0;
                    e_next  = e_reg >> 1;
                    if ((e_reg >> 1) != '0)
                    begin
                        xr_next    = RG_B;
                        yr_next    = RG_B;
                        dr_next    = RG_B;
                        state_next = S_MM_RX;
                    end
                end
            end
            S_MM_RX:
            begin
                state_next = S_MM_RY;
            end
            S_MM_RY:
            begin
                mu_a_next  = wrd_reg;
                state_next = S_MM_GO;
            end
            S_MM_GO:
            begin
                mu_b_next   = wrd_reg;
                mu_acc_next = '0;
                cnt_next    = '0;
                ret_next    = S_MM_ACC;
                state_next  = S_MUL;
            end
            S_MM_ACC:
            begin
                sum_next   = add_mod(sum_reg, mu_acc_reg, meff);
                ck_next    = ck_reg + 5'd1;
                state_next = last_k ? S_MM_WR : S_MM_RX;
            end
            S_MM_WR:
            begin
                w_we     = 1'b1;
                w_waddr  = {RG_S, ent(ci_reg, cj_reg)};
                w_wdata  = sum_reg;
                sum_next = '0;
                ck_next  = '0;
                cj_next  = cj_reg + 5'd1;
                state_next = S_MM_RX;
                if (last_j)
                begin
                    cj_next = '0;
                    ci_next = ci_reg + 5'd1;
                    if (last_i)
                    begin
                        ci_next    = '0;
                        state_next = S_CP_RD;
                    end
                end
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                w_we    = 1'b1;
                w_waddr = {dr_reg, ent(ci_reg, cj_reg)};
                w_wdata = wrd_reg;
                cj_next = cj_reg + 5'd1;
                state_next = S_CP_RD;
                if (last_j)
                begin
                    cj_next = '0;
                    ci_next = ci_reg + 5'd1;
                    if (last_i)
                    begin
                        ci_next    = '0;
                        state_next = S_LOOP;
                    end
                end
            end
            S_MV_RD:
            begin
                state_next = S_MV_MOD;
            end
            S_MV_MOD:
            begin
                mu_a_next   = wrd_reg;
                md_a_next   = vrdv_reg ? vrd_reg : '0;
                md_rem_next = '0;
                cnt_next    = '0;
                ret_next    = S_MV_GO;
                state_next  = S_MOD;
            end
            S_MV_GO:
            begin
                mu_b_next   = md_rem_reg;
                mu_acc_next = '0;
                cnt_next    = '0;
                ret_next    = S_MV_ACC;
                state_next  = S_MUL;
            end
            S_MV_ACC:
            begin
                sum_next   = add_mod(sum_reg, mu_acc_reg, meff);
                cj_next    = cj_reg + 5'd1;
                state_next = last_j ? S_MV_OUT : S_MV_RD;
            end
            S_MV_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = ci_reg[IDX_W-1:0];
                    oval_next  = sum_reg;
                    olast_next = last_i;
                    sum_next   = '0;
                    cj_next    = '0;
                    ci_next    = ci_reg + 5'd1;
                    state_next = last_i ? S_IDLE : S_MV_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            mod_reg      <= val_t'(1000000007);
            size_reg     <= 5'd16;
            e_reg        <= '0;
            op_reg       <= 1'b0;
            s_reg        <= 5'd1;
            ci_reg       <= '0;
            cj_reg       <= '0;
            ck_reg       <= '0;
            xr_reg       <= RG_P;
            yr_reg       <= RG_P;
            dr_reg       <= RG_P;
            md_a_reg     <= '0;
            md_rem_reg   <= '0;
            cnt_reg      <= '0;
            mu_a_reg     <= '0;
            mu_b_reg     <= '0;
            mu_acc_reg   <= '0;
            sum_reg      <= '0;
            ld_addr_reg  <= '0;
            ld_vaddr_reg <= '0;
            ld_vec_reg   <= 1'b0;
            ov_reg       <= 1'b0;
            olast_reg    <= 1'b0;
            oidx_reg     <= '0;
            oval_reg     <= '0;
            mvld_reg     <= '0;
            vvld_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            mod_reg      <= mod_next;
            size_reg     <= size_next;
            e_reg        <= e_next;
            op_reg       <= op_next;
            s_reg        <= s_next;
            ci_reg       <= ci_next;
            cj_reg       <= cj_next;
            ck_reg       <= ck_next;
            xr_reg       <= xr_next;
            yr_reg       <= yr_next;
            dr_reg       <= dr_next;
            md_a_reg     <= md_a_next;
            md_rem_reg   <= md_rem_next;
            cnt_reg      <= cnt_next;
            mu_a_reg     <= mu_a_next;
            mu_b_reg     <= mu_b_next;
            mu_acc_reg   <= mu_acc_next;
            sum_reg      <= sum_next;
            ld_addr_reg  <= ld_addr_next;
            ld_vaddr_reg <= ld_vaddr_next;
            ld_vec_reg   <= ld_vec_next;
            ov_reg       <= ov_next;
            olast_reg    <= olast_next;
            oidx_reg     <= oidx_next;
            oval_reg     <= oval_next;
            if (m_we)
            begin
                mvld_reg[ld_addr_reg] <= 1'b1;
            end
            if (v_we)
            begin
                vvld_reg[ld_vaddr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mem_m[ld_addr_reg] <= md_rem_reg;
        end
        mrd_reg  <= mem_m[m_raddr];
        mrdv_reg <= mvld_reg[m_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            mem_v[ld_vaddr_reg] <= md_rem_reg;
        end
        vrd_reg  <= mem_v[v_raddr];
        vrdv_reg <= vvld_reg[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            mem_w[w_waddr] <= w_wdata;
        end
        wrd_reg <= mem_w[w_raddr];
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {6'd0, oval_reg, oidx_reg};

endmodule

// ----- design/mmpv_checker.sv -----
// Port-level assertions for the modular matrix power vector block, with bind.
`timescale 1ns / 1ps

module mmpv_checker
    import mmpv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [135:0]       s_axis_tdata,
    input logic [KIND_W-1:0]  s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [71:0]        m_axis_tdata,
    input logic               m_axis_tlast,
    input logic               wr_en,
    input logic               wr_index,
    input logic [VAL_W-1:0]   wr_data
);

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata[135:0], wr_en, wr_index, wr_data};

    a_rst_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_START) |=> !s_axis_tready)
        else $error("input accepted right after a start transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output changed");

endmodule

bind modular_matrix_power_vector mmpv_checker u_mmpv_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the modular matrix power vector block.
`timescale 1ns / 1ps

module tb_top;
    import mmpv_pkg::*;

    localparam int  N        = 16;
    localparam int  LIMIT    = 25000000;
    localparam int  SETTLE   = 100;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic [VAL_W-1:0]  VAL_MAX = {VAL_W{1'b1}};
    localparam logic [EXP_W-1:0]  EXP_MAX = {EXP_W{1'b1}};

    typedef enum logic [1:0] {ROW_ITEM, ROW_MOD, ROW_SIZE} row_op_t;

    typedef struct {
        row_op_t            op;
        logic [KIND_W-1:0]  kind;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [VAL_W-1:0]   value;
        logic [EXP_W-1:0]   power;
        bit                 typed;
        logic [VAL_W-1:0]   typed_value;
    } stim_row_t;

    typedef struct {
        logic [3:0]       index;
        logic [VAL_W-1:0] value;
        logic             last;
    } entry_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [135:0]       s_axis_tdata;
    logic [KIND_W-1:0]  s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [71:0]        m_axis_tdata;
    logic               m_axis_tlast;
    logic               wr_en;
    logic               wr_index;
    logic [VAL_W-1:0]   wr_data;

    modular_matrix_power_vector #(.DIM(N)) dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor state
    logic [VAL_W-1:0] mod_reg;
    logic [4:0]       size_reg;
    logic [VAL_W-1:0] mat_copy [N*N];
    logic [VAL_W-1:0] vec_copy [N];
    logic [VAL_W-1:0] pow_acc  [N*N];
    logic [VAL_W-1:0] sq_base  [N*N];
    logic [VAL_W-1:0] scratch  [N*N];

    entry_t     pending_entries [$];
    int         errors;
    int         cycles;
    int         items_sent;
    int         starts_sent;
    int         entries_seen;
    bit         sender_idle_on;
    bit         recv_idle_on;
    int         stall_left;

    function automatic logic [VAL_W-1:0] eff_mod();
        return (mod_reg == '0) ? VAL_W'(1) : mod_reg;
    endfunction

    function automatic int eff_size();
        if (size_reg < 1)
            return 1;
        if (size_reg > N)
            return N;
        return int'(size_reg);
    endfunction

    function automatic logic [VAL_W-1:0] mul_mod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                                 logic [VAL_W-1:0] m);
        logic [127:0] p;
        p = ({66'b0, a} * {66'b0, b}) % {66'b0, m};
        return p[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sum_mod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                                 logic [VAL_W-1:0] m);
        logic [VAL_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, m})
            t = t - {1'b0, m};
        return t[VAL_W-1:0];
    endfunction

    // scratch = x * y, into_base picks x: 0 power accumulator, 1 squared base
    task automatic matrix_product(bit into_base, int s, logic [VAL_W-1:0] m);
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] x;
        for (int i = 0; i < s; i++)
            for (int j = 0; j < s; j++)
            begin
                acc = '0;
                for (int k = 0; k < s; k++)
                begin
                    x = into_base ? sq_base[i*N+k] : pow_acc[i*N+k];
                    acc = sum_mod(acc, mul_mod(x, sq_base[k*N+j], m), m);
                end
                scratch[i*N+j] = acc;
            end
        for (int i = 0; i < s; i++)
            for (int j = 0; j < s; j++)
                if (into_base)
                    sq_base[i*N+j] = scratch[i*N+j];
                else
                    pow_acc[i*N+j] = scratch[i*N+j];
    endtask

    task automatic apply_item(logic [KIND_W-1:0] kind, logic [3:0] row, logic [3:0] col,
                              logic [VAL_W-1:0] value, logic [EXP_W-1:0] power,
                              bit typed, logic [VAL_W-1:0] typed_value);
        logic [VAL_W-1:0] m;
        logic [EXP_W-1:0] e;
        logic [VAL_W-1:0] acc;
        entry_t           ent;
        int               s;
        m = eff_mod();
        if (kind == KIND_MATRIX)
            mat_copy[row*N+col] = value % m;
        else if (kind == KIND_VECTOR)
            vec_copy[row] = value % m;
        else if (kind == KIND_START)
        begin
            s = eff_size();
            e = power;
            starts_sent++;
            for (int i = 0; i < s; i++)
                for (int j = 0; j < s; j++)
                begin
                    pow_acc[i*N+j] = (i == j) ? (VAL_W'(1) % m) : '0;
                    sq_base[i*N+j] = mat_copy[i*N+j] % m;
                end
            while (e != '0)
            begin
                if (e[0])
                    matrix_product(1'b0, s, m);
                e = e >> 1;
                if (e != '0)
                    matrix_product(1'b1, s, m);
            end
            for (int i = 0; i < s; i++)
            begin
                acc = '0;
                for (int j = 0; j < s; j++)
                    acc = sum_mod(acc, mul_mod(pow_acc[i*N+j], vec_copy[j] % m, m), m);
                ent.index = 4'(i);
                ent.value = typed ? typed_value : acc;
                ent.last  = (i + 1 == s);
                pending_entries.push_back(ent);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VAL_W-1:0];
    endfunction

    function automatic logic [EXP_W-1:0] rand_exp(int bits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        r = (bits >= 64) ? r : (r & ((64'd1 << bits) - 1));
        return r[EXP_W-1:0];
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic [3:0] row, logic [3:0] col,
                             logic [VAL_W-1:0] value, logic [EXP_W-1:0] power,
                             bit typed, logic [VAL_W-1:0] typed_value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b0, power, value, col, row};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_item(kind, row, col, value, power, typed, typed_value);
        items_sent++;
        if (sender_idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = gap_len();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [VAL_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
        if (idx == REG_MODULUS)
            mod_reg = data;
        else
            size_reg = data[4:0];
        @(posedge clk);
    endtask

    // output monitor
    always @(posedge clk)
    begin
        entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            entries_seen++;
            if (pending_entries.size() == 0)
            begin
                $display("unexpected output transaction at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                want = pending_entries.pop_front();
                if (m_axis_tdata[3:0] != want.index)
                    report_mismatch("index", VAL_W'(m_axis_tdata[3:0]), VAL_W'(want.index));
                if (m_axis_tdata[65:4] != want.value)
                    report_mismatch("result_value", m_axis_tdata[65:4], want.value);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", VAL_W'(m_axis_tlast), VAL_W'(want.last));
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    stim_row_t directed [$];

    task automatic add_row(row_op_t op, logic [KIND_W-1:0] kind, logic [3:0] row,
                           logic [3:0] col, logic [VAL_W-1:0] value,
                           logic [EXP_W-1:0] power, bit typed, logic [VAL_W-1:0] tv);
        stim_row_t r;
        r = '{op, kind, row, col, value, power, typed, tv};
        directed.push_back(r);
    endtask

    initial
    begin
        int s;
        int n_mat;
        int bits;
        int r;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_MATRIX;
        m_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_MODULUS;
        wr_data       = '0;
        errors = 0; cycles = 0; items_sent = 0; starts_sent = 0; entries_seen = 0;
        stall_left = 0;
        sender_idle_on = 1'b0;
        recv_idle_on   = 1'b0;
        mod_reg  = VAL_W'(1000000007);
        size_reg = 5'd16;
        for (int i = 0; i < N*N; i++)
            mat_copy[i] = '0;
        for (int i = 0; i < N; i++)
            vec_copy[i] = '0;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset everything is zero
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, 0, 1, 0);
        add_row(ROW_SIZE, 0, 0, 0, 1, 0, 0, 0);
        add_row(ROW_MOD, 0, 0, 0, VAL_MAX, 0, 0, 0);
        add_row(ROW_ITEM, KIND_MATRIX, 0, 0, VAL_MAX, 0, 0, 0);
        add_row(ROW_ITEM, KIND_VECTOR, 0, 0, VAL_MAX - 1, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, EXP_MAX, 1, 0);
        add_row(ROW_ITEM, KIND_MATRIX, 0, 0, 3, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, EXP_MAX, 0, 0);
        add_row(ROW_ITEM, KIND_NONE, 4'hf, 4'hf, VAL_MAX, EXP_MAX, 0, 0);
        add_row(ROW_ITEM, KIND_MATRIX, 4'hf, 4'hf, VAL_MAX - 5, 0, 0, 0);
        add_row(ROW_ITEM, KIND_VECTOR, 4'hf, 0, 12345, 0, 0, 0);
        add_row(ROW_SIZE, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, 5, 0, 0);
        add_row(ROW_SIZE, 0, 0, 0, 31, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, 0, 0, 0);
        add_row(ROW_MOD, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_SIZE, 0, 0, 0, 2, 0, 0, 0);
        add_row(ROW_ITEM, KIND_MATRIX, 1, 1, 9, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, 3, 1, 0);
        add_row(ROW_MOD, 0, 0, 0, 1, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, 1, 1, 0);
        add_row(ROW_MOD, 0, 0, 0, 2, 0, 0, 0);
        add_row(ROW_ITEM, KIND_MATRIX, 1, 0, 5, 0, 0, 0);
        add_row(ROW_ITEM, KIND_VECTOR, 1, 0, 7, 0, 0, 0);
        add_row(ROW_ITEM, KIND_START, 0, 0, 0, 4, 0, 0);

        foreach (directed[i])
        begin
            if (directed[i].op == ROW_ITEM)
                send_item(directed[i].kind, directed[i].row, directed[i].col,
                          directed[i].value, directed[i].power,
                          directed[i].typed, directed[i].typed_value);
            else
            begin
                drain();
                write_reg(directed[i].op == ROW_MOD ? REG_MODULUS : REG_SIZE,
                          directed[i].value);
            end
        end

        while (items_sent < 145)
        begin
            drain();
            sender_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on   = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0: write_reg(REG_MODULUS, VAL_W'($urandom_range(2, 20)));
                1: write_reg(REG_MODULUS, VAL_MAX - VAL_W'($urandom_range(0, 3)));
                2: write_reg(REG_MODULUS, VAL_W'(1000000007));
                default: write_reg(REG_MODULUS, rand_val() >> $urandom_range(0, 60));
            endcase
            r = $urandom_range(0, 9);
            s = (r < 3) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : (r < 9) ? 4 : $urandom_range(5, 8);
            write_reg(REG_SIZE, VAL_W'(s));
            n_mat = $urandom_range(1, s * s < 6 ? s * s : 6);
            for (int k = 0; k < n_mat; k++)
                send_item(KIND_MATRIX, 4'($urandom_range(0, s - 1)),
                          4'($urandom_range(0, s - 1)), rand_val(), rand_exp(63), 0, 0);
            for (int k = 0; k < $urandom_range(1, 3); k++)
                send_item(KIND_VECTOR, 4'($urandom_range(0, s - 1)), 4'($urandom),
                          rand_val(), rand_exp(63), 0, 0);
            if ($urandom_range(0, 3) == 0)
                send_item($urandom_range(0, 1) ? KIND_NONE : KIND_MATRIX,
                          4'($urandom), 4'($urandom), rand_val(), rand_exp(63), 0, 0);
            bits = (s <= 2) ? $urandom_range(1, 63) : (s == 3) ? $urandom_range(1, 14) :
                   (s == 4) ? $urandom_range(1, 9) : 2;
            send_item(KIND_START, 4'($urandom), 4'($urandom), rand_val(), rand_exp(bits), 0, 0);
        end

        drain();
        $display("covered %0d input transactions, %0d starts, %0d result entries",
                 items_sent, starts_sent, entries_seen);
        $display("moduli from 0 to 2^62-1, sizes 1 to 16 with clamping, exponents to 63 bits");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
